FILE: rtl/core/lrmt_pkg.sv
// ----------------------------------------------------------------------------
// LFSR random memory test package
// Shared types, codes and constants for the memory self-test engine.
// ----------------------------------------------------------------------------
package lrmt_pkg;

    localparam logic [31:0] LFSR_SEED  = 32'h1234_5678;
    localparam logic [31:0] LFSR_TAPS  = 32'hA300_0000;
    localparam logic [31:0] DATA_XOR   = 32'hA5A5_A5A5;
    localparam logic [31:0] WORD_BYTES = 32'd4;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_WRITE = 2'd1;
    localparam logic [1:0] PH_READ  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_DONE  = 2'd2;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_GRANT = 1'b1;

    localparam logic [1:0] CFG_START_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_END_ADDRESS   = 2'd1;
    localparam logic [1:0] CFG_NUM_ACCESSES  = 2'd2;

    typedef struct packed {
        logic [31:0] start_address;
        logic [31:0] end_address;
        logic [31:0] num_accesses;
    } t_cfg;

    typedef struct packed {
        logic [31:0] lfsr_value;
        logic [1:0]  test_phase;
        logic [31:0] access_index;
        logic [31:0] pending_address;
        logic        pending_is_read;
        logic [15:0] mismatch_total;
    } t_state;

    typedef struct packed {
        logic [1:0]  request_op;
        logic [31:0] request_address;
        logic [31:0] request_data;
        logic        mismatch;
        logic [15:0] errors_seen;
        logic        test_pass;
    } t_result;

    function automatic logic [31:0] lfsr_advance(input logic [31:0] v);
        logic [31:0] shifted;
        shifted = {1'b0, v[31:1]};
        return v[0] ? (shifted ^ LFSR_TAPS) : shifted;
    endfunction

endpackage

FILE: rtl/core/lfsr_random_memory_test_top.sv
// ----------------------------------------------------------------------------
// LFSR random memory test engine
// Issues LFSR-addressed write and read requests and checks the read data.
// ----------------------------------------------------------------------------
// Each accepted item is handled by combinational step logic, so an item can be
// accepted on every clock while o_in_stall is low. A start transfer seeds the
// LFSR and begins the write pass; each grant transfer in the write or read pass
// returns the next request, or the final pass/fail result. The result goes into
// a two-entry output buffer, so the input stalls only when two results wait to
// be taken. Write the configuration registers only while the engine is idle.
module lfsr_random_memory_test_top import lrmt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [31:0] i_read_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_request_op,
    output logic [31:0] o_request_address,
    output logic [31:0] o_request_data,
    output logic        o_mismatch,
    output logic [15:0] o_errors_seen,
    output logic        o_test_pass
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result step_result;
    t_result out_data;
    logic    produce;
    logic    accept;
    logic    full;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_ADDRESS: r_cfg.start_address <= i_cfg_data;
                CFG_END_ADDRESS:   r_cfg.end_address   <= i_cfg_data;
                CFG_NUM_ACCESSES:  r_cfg.num_accesses  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lrmt_step u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_kind      (i_kind),
        .i_read_data (i_read_data),
        .o_state     (n_state),
        .o_result    (step_result),
        .o_produce   (produce)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.lfsr_value      <= LFSR_SEED;
            r_state.test_phase      <= PH_IDLE;
            r_state.access_index    <= '0;
            r_state.pending_address <= '0;
            r_state.pending_is_read <= 1'b0;
            r_state.mismatch_total  <= '0;
        end else if (accept && produce) begin
            r_state <= n_state;
        end
    end

    lrmt_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && produce),
        .i_data  (step_result),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_data)
    );

    assign o_request_op      = out_data.request_op;
    assign o_request_address = out_data.request_address;
    assign o_request_data    = out_data.request_data;
    assign o_mismatch        = out_data.mismatch;
    assign o_errors_seen     = out_data.errors_seen;
    assign o_test_pass       = out_data.test_pass;

endmodule

FILE: rtl/core/lrmt_step.sv
// ----------------------------------------------------------------------------
// LFSR random memory test step logic
// Computes the next engine state and the result for one accepted item.
// ----------------------------------------------------------------------------
module lrmt_step import lrmt_pkg::*; (
    input  t_cfg        i_cfg,
    input  t_state      i_state,
    input  logic        i_kind,
    input  logic [31:0] i_read_data,
    output t_state      o_state,
    output t_result     o_result,
    output logic        o_produce
);

    t_state      s0;
    t_state      s1;
    logic        miss;
    logic [31:0] mask;
    logic [31:0] addr;
    logic        all_done;

    always_comb begin
        s0   = i_state;
        miss = 1'b0;
        o_produce = 1'b1;
        if (i_kind == KIND_START) begin
            s0.lfsr_value      = LFSR_SEED;
            s0.test_phase      = PH_WRITE;
            s0.access_index    = '0;
            s0.pending_address = '0;
            s0.pending_is_read = 1'b0;
            s0.mismatch_total  = '0;
        end else begin
            if (i_state.test_phase != PH_WRITE && i_state.test_phase != PH_READ) begin
                o_produce = 1'b0;
            end
            if (i_state.pending_is_read &&
                i_read_data != (i_state.pending_address ^ DATA_XOR)) begin
                miss = 1'b1;
                if (i_state.mismatch_total != COUNT_MAX) begin
                    s0.mismatch_total = i_state.mismatch_total + 16'd1;
                end
            end
        end

        s1 = s0;
        if (s0.test_phase == PH_WRITE && s0.access_index >= i_cfg.num_accesses) begin
            s1.test_phase   = PH_READ;
            s1.lfsr_value   = LFSR_SEED;
            s1.access_index = '0;
        end
        all_done = (s1.test_phase == PH_READ) && (s1.access_index >= i_cfg.num_accesses);

        mask = (i_cfg.end_address - i_cfg.start_address) - WORD_BYTES;
        addr = i_cfg.start_address + (s1.lfsr_value & mask);

        o_result.mismatch    = miss;
        o_result.errors_seen = s1.mismatch_total;
        o_state = s1;
        if (all_done) begin
            o_state.test_phase         = PH_DONE;
            o_state.pending_is_read    = 1'b0;
            o_result.request_op        = OP_DONE;
            o_result.request_address   = '0;
            o_result.request_data      = '0;
            o_result.test_pass         = (s1.mismatch_total == '0);
        end else begin
            o_state.pending_address    = addr;
            o_state.pending_is_read    = (s1.test_phase == PH_READ);
            o_state.lfsr_value         = lfsr_advance(s1.lfsr_value);
            o_state.access_index       = s1.access_index + 32'd1;
            o_result.request_op        = (s1.test_phase == PH_READ) ? OP_READ : OP_WRITE;
            o_result.request_address   = addr;
            o_result.request_data      = addr ^ DATA_XOR;
            o_result.test_pass         = 1'b0;
        end
    end

endmodule

FILE: rtl/core/lrmt_out_queue.sv
// ----------------------------------------------------------------------------
// LFSR random memory test output queue
// Two-entry result buffer that separates the input and output handshakes.
// ----------------------------------------------------------------------------
module lrmt_out_queue import lrmt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    t_result    r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop     = (r_count != 2'd0) && !i_stall;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

endmodule
